// File: sv/dtq_pkg.sv
// Package for the delta timer queue: widths, opcodes, status codes, cell types.
// No dependencies.
package dtq_pkg;
	localparam int TASK_COUNT = 64;
	localparam int TICK_BITS  = 32;
	localparam int ID_BITS    = 6;
	localparam int POS_BITS   = $clog2(TASK_COUNT + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_PEEK   = 2'd2,
		OP_TAKE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_QUEUED = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_TAKE   = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [ID_BITS-1:0]     task_id;
		logic [TICK_BITS-1:0]   ticks;
	} cmd_t;

	typedef struct packed {
		logic                   valid;
		logic [ID_BITS-1:0]     task_id;
		logic [TICK_BITS-1:0]   delta;
	} slot_t;

	typedef struct packed {
		logic                   busy;
		logic                   found;
	} token_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_WALK = 2'd1,
		FSM_OUT  = 2'd2
	} fsm_t;
endpackage

// File: sv/dtq_if.sv
// Valid/ready channel interface for the delta timer queue.
// Depends on dtq_pkg.
interface dtq_in_if (input logic clk);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    op;
	logic [dtq_pkg::ID_BITS-1:0]   task_id;
	logic [dtq_pkg::TICK_BITS-1:0] delay_ticks;
	modport source (output valid, op, task_id, delay_ticks, input ready);
	modport sink (input valid, op, task_id, delay_ticks, output ready);
endinterface

interface dtq_out_if (input logic clk);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic                          head_valid;
	logic [dtq_pkg::ID_BITS-1:0]   head_task;
	logic [dtq_pkg::TICK_BITS-1:0] head_delta;
	modport source (output valid, status, head_valid, head_task, head_delta, input ready);
	modport sink (input valid, status, head_valid, head_task, head_delta, output ready);
endinterface

// File: sv/delta_timer_queue_core.sv
// Delta timer queue built as a row of TASK_COUNT cells.
// Insert and remove: the token walks the row, one cell a cycle.
// Peek, take and rejected commands: result in the cycle after the input beat, next beat
// once that result is accepted; a take's shift ripples down the row behind it.
// One item at a time; a result waits in the output register until it is accepted.
// Reset clears every cell valid bit; the queue is empty after reset.
module delta_timer_queue_core (
	input logic        clk,
	input logic        arst_n,
	dtq_in_if.sink     in_ch,
	dtq_out_if.source  out_ch
);
	localparam int N = dtq_pkg::TASK_COUNT;

	dtq_pkg::cmd_t   cmd_w [N+1];
	dtq_pkg::token_t tok_w [N+1];
	dtq_pkg::slot_t  slot_w [N];
	dtq_pkg::slot_t  rgt [N];

	dtq_pkg::fsm_t   state_q, state_d;
	logic [dtq_pkg::POS_BITS-1:0] cnt_q, cnt_d;
	logic [N-1:0]    queued_q;
	logic            start;
	dtq_pkg::cmd_t   launch;
	logic [1:0]      status_q;
	logic            hv_q;
	logic [dtq_pkg::ID_BITS-1:0]   ht_q;
	logic [dtq_pkg::TICK_BITS-1:0] hd_q;
	logic            take_go;

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_row
			assign rgt[g] = (g == N-1) ? '0 : slot_w[(g == N-1) ? g : g+1];
			dtq_cell u_cell (
				.clk(clk), .arst_n(arst_n),
				.cmd_in(cmd_w[g]), .tok_in(tok_w[g]),
				.right_slot(rgt[g]),
				.cmd_out(cmd_w[g+1]), .tok_out(tok_w[g+1]), .slot(slot_w[g])
			);
		end
	endgenerate

	assign cmd_w[0] = take_go ? '{kind: dtq_pkg::CMD_TAKE, task_id: slot_w[0].task_id,
		ticks: '0} : launch;
	assign tok_w[0] = '{busy: start || take_go, found: 1'b0};

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		start   = 1'b0;
		launch  = '{kind: dtq_pkg::CMD_HOLD, task_id: in_ch.task_id, ticks: in_ch.delay_ticks};
		unique case (state_q)
			dtq_pkg::FSM_IDLE: begin
				if (in_ch.valid) begin
					state_d = dtq_pkg::FSM_OUT;
					if ((in_ch.op == dtq_pkg::OP_INSERT && !queued_q[in_ch.task_id]) ||
						(in_ch.op == dtq_pkg::OP_REMOVE && queued_q[in_ch.task_id])) begin
						start       = 1'b1;
						launch.kind = (in_ch.op == dtq_pkg::OP_INSERT) ?
							dtq_pkg::CMD_INSERT : dtq_pkg::CMD_REMOVE;
						state_d     = dtq_pkg::FSM_WALK;
						cnt_d       = '0;
					end
				end
			end
			dtq_pkg::FSM_WALK: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == dtq_pkg::POS_BITS'(N))
					state_d = dtq_pkg::FSM_OUT;
			end
			dtq_pkg::FSM_OUT: begin
				if (out_ch.ready)
					state_d = dtq_pkg::FSM_IDLE;
			end
			default: state_d = dtq_pkg::FSM_IDLE;
		endcase
	end

	assign in_ch.ready = (state_q == dtq_pkg::FSM_IDLE);
	assign take_go = in_ch.valid && in_ch.ready && in_ch.op == dtq_pkg::OP_TAKE &&
		slot_w[0].valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dtq_pkg::FSM_IDLE;
			cnt_q    <= '0;
			queued_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (start)
				queued_q[in_ch.task_id] <= (in_ch.op == dtq_pkg::OP_INSERT);
			if (take_go)
				queued_q[slot_w[0].task_id] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			hv_q <= 1'b0;
			ht_q <= '0;
			hd_q <= '0;
			unique case (in_ch.op)
				dtq_pkg::OP_INSERT: status_q <= queued_q[in_ch.task_id] ?
					dtq_pkg::ST_QUEUED : dtq_pkg::ST_DONE;
				dtq_pkg::OP_REMOVE: status_q <= queued_q[in_ch.task_id] ?
					dtq_pkg::ST_DONE : dtq_pkg::ST_ABSENT;
				default: begin
					if (slot_w[0].valid) begin
						status_q <= dtq_pkg::ST_DONE;
						hv_q     <= 1'b1;
						ht_q     <= slot_w[0].task_id;
						hd_q     <= slot_w[0].delta;
					end else begin
						status_q <= dtq_pkg::ST_EMPTY;
					end
				end
			endcase
		end
	end

	assign out_ch.valid      = (state_q == dtq_pkg::FSM_OUT);
	assign out_ch.status     = status_q;
	assign out_ch.head_valid = hv_q;
	assign out_ch.head_task  = ht_q;
	assign out_ch.head_delta = hd_q;
endmodule

// File: sv/dtq_cell.sv
// One slot of the sorted queue; a command token ripples through the row one cell a cycle.
// Depends on dtq_pkg.
module dtq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  dtq_pkg::cmd_t     cmd_in,
	input  dtq_pkg::token_t   tok_in,
	input  dtq_pkg::slot_t    right_slot,
	output dtq_pkg::cmd_t     cmd_out,
	output dtq_pkg::token_t   tok_out,
	output dtq_pkg::slot_t    slot
);
	dtq_pkg::slot_t  slot_q;
	dtq_pkg::cmd_t   cmd_q;
	dtq_pkg::token_t tok_q;
	dtq_pkg::slot_t  slot_d;
	dtq_pkg::cmd_t   cmd_d;
	logic            found_d;

	// Insert: before found, subtract while ticks > delta; from the found cell on, take the
	// carried entry and carry own entry right; stop once an empty slot is filled.
	// Remove and take: at the match pull the right entry in; after found, shift left.
	// Remove adds own delta to the successor, take leaves it.
	always_comb begin
		slot_d  = slot_q;
		cmd_d   = cmd_in;
		found_d = tok_in.found;
		if (tok_in.busy) begin
			unique case (cmd_in.kind)
				dtq_pkg::CMD_INSERT: begin
					if (!tok_in.found && slot_q.valid && cmd_in.ticks > slot_q.delta) begin
						cmd_d.ticks = cmd_in.ticks - slot_q.delta;
					end else begin
						found_d        = 1'b1;
						slot_d.valid   = 1'b1;
						slot_d.task_id = cmd_in.task_id;
						slot_d.delta   = cmd_in.ticks;
						cmd_d.task_id  = slot_q.task_id;
						cmd_d.ticks    = tok_in.found ? slot_q.delta :
							slot_q.delta - cmd_in.ticks;
						if (!slot_q.valid)
							cmd_d.kind = dtq_pkg::CMD_HOLD;
					end
				end
				dtq_pkg::CMD_REMOVE, dtq_pkg::CMD_TAKE: begin
					if (tok_in.found) begin
						slot_d = right_slot;
					end else if (slot_q.valid && slot_q.task_id == cmd_in.task_id) begin
						found_d = 1'b1;
						slot_d  = right_slot;
						if (right_slot.valid && cmd_in.kind == dtq_pkg::CMD_REMOVE)
							slot_d.delta = right_slot.delta + slot_q.delta;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			tok_q  <= '0;
		end else begin
			slot_q <= slot_d;
			tok_q  <= '{busy: tok_in.busy, found: found_d};
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
	end

	assign slot    = slot_q;
	assign cmd_out = cmd_q;
	assign tok_out = tok_q;
endmodule

// File: sv/dtq_checker.sv
// Port-level checker for the delta timer queue, bound to the top level.
// Depends on dtq_pkg and the channel interfaces.
module dtq_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] status,
	input logic head_valid,
	input logic [dtq_pkg::ID_BITS-1:0] head_task
);
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_hv_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && head_valid |-> status == dtq_pkg::ST_DONE) else $error("head with bad status");
	a_hv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !head_valid |-> head_task == '0) else $error("stray head id");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)) else $error("result dropped");
endmodule

bind delta_timer_queue_core dtq_checker u_dtq_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.status(out_ch.status), .head_valid(out_ch.head_valid), .head_task(out_ch.head_task)
);

// File: sim/tb.sv
// Testbench for delta_timer_queue_core: random and directed queue commands, each result
// checked against a behavioural model of the delta list.
// Depends on dtq_pkg, dtq_if and the core.
`timescale 1ns / 100ps

class wake_scoreboard;
	bit [31:0] delta_q [64];
	bit [6:0]  nxt [64];
	bit [6:0]  prv [64];
	bit        queued [64];
	bit [6:0]  head, tail;
	bit [1:0]  st_q [$];
	bit        hv_q [$];
	bit [5:0]  ht_q [$];
	bit [31:0] hd_q [$];
	int        errors;

	function new();
		for (int i = 0; i < 64; i++) begin
			nxt[i] = 64;
			prv[i] = 64;
			queued[i] = 0;
			delta_q[i] = 0;
		end
		head = 64;
		tail = 64;
		errors = 0;
	endfunction

	function void push(bit [1:0] s, bit v, bit [5:0] t, bit [31:0] d);
		st_q.push_back(s);
		hv_q.push_back(v);
		ht_q.push_back(t);
		hd_q.push_back(d);
	endfunction

	function void note_command(dtq_pkg::op_t op, bit [5:0] id, bit [31:0] ticks);
		bit [6:0] cur, p, n, h;
		if (op == dtq_pkg::OP_INSERT) begin
			if (queued[id]) begin
				push(dtq_pkg::ST_QUEUED, 0, 0, 0);
				return;
			end
			cur = head;
			while (cur < 64 && ticks > delta_q[cur]) begin
				ticks -= delta_q[cur];
				cur = nxt[cur];
			end
			if (cur < 64) begin
				p = prv[cur];
				prv[id] = p;
				if (p < 64) nxt[p] = id;
				else head = id;
				prv[cur] = id;
				nxt[id] = cur;
				delta_q[cur] -= ticks;
			end else if (tail < 64) begin
				nxt[tail] = id;
				prv[id] = tail;
				nxt[id] = 64;
				tail = id;
			end else begin
				head = id;
				tail = id;
				nxt[id] = 64;
				prv[id] = 64;
			end
			delta_q[id] = ticks;
			queued[id] = 1;
			push(dtq_pkg::ST_DONE, 0, 0, 0);
		end else if (op == dtq_pkg::OP_REMOVE) begin
			if (!queued[id]) begin
				push(dtq_pkg::ST_ABSENT, 0, 0, 0);
				return;
			end
			p = prv[id];
			n = nxt[id];
			if (p < 64) nxt[p] = n;
			else head = n;
			if (n < 64) begin
				delta_q[n] += delta_q[id];
				prv[n] = p;
			end else tail = p;
			nxt[id] = 64;
			prv[id] = 64;
			queued[id] = 0;
			push(dtq_pkg::ST_DONE, 0, 0, 0);
		end else if (head >= 64) begin
			push(dtq_pkg::ST_EMPTY, 0, 0, 0);
		end else begin
			h = head;
			push(dtq_pkg::ST_DONE, 1, h[5:0], delta_q[h]);
			if (op == dtq_pkg::OP_TAKE) begin
				n = nxt[h];
				head = n;
				if (n < 64) prv[n] = 64;
				else tail = 64;
				nxt[h] = 64;
				prv[h] = 64;
				queued[h] = 0;
			end
		end
	endfunction

	function void check_result(bit [1:0] s, bit v, bit [5:0] t, bit [31:0] d);
		bit [1:0] es;
		bit ev;
		bit [5:0] et;
		bit [31:0] ed;
		if (st_q.size() == 0) begin
			$error("result with nothing pending");
			errors++;
			return;
		end
		es = st_q.pop_front();
		ev = hv_q.pop_front();
		et = ht_q.pop_front();
		ed = hd_q.pop_front();
		if (s !== es) begin
			$error("status expected %0d actual %0d", es, s);
			errors++;
		end
		if (v !== ev) begin
			$error("head_valid expected %0d actual %0d", ev, v);
			errors++;
		end
		if (t !== et) begin
			$error("head_task expected %0d actual %0d", et, t);
			errors++;
		end
		if (d !== ed) begin
			$error("head_delta expected %0d actual %0d", ed, d);
			errors++;
		end
	endfunction

	function int pending();
		return st_q.size();
	endfunction
endclass

module tb;
	logic clk = 0;
	logic arst_n = 0;
	int   cycles = 0;
	bit   calm = 0;
	bit   hold_off = 0;
	wake_scoreboard sb = new();

	dtq_in_if  in_ch (clk);
	dtq_out_if out_ch (clk);

	delta_timer_queue_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always #4 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.op = 0;
		in_ch.task_id = 0;
		in_ch.delay_ticks = 0;
		out_ch.ready = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.status, out_ch.head_valid, out_ch.head_task,
				out_ch.head_delta);

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ch.ready <= 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 17);
				out_ch.ready <= 0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				out_ch.ready <= 1;
			end
		end
	end

	task automatic send_cmd(dtq_pkg::op_t op, bit [5:0] id, bit [31:0] ticks);
		int gap;
		if (!calm && $urandom_range(0, 6) == 0) begin
			gap = $urandom_range(1, 17);
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.op <= op;
		in_ch.task_id <= id;
		in_ch.delay_ticks <= ticks;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_command(op, id, ticks);
	endtask

	function automatic bit [31:0] rand_ticks();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			2: return $urandom;
			default: return $urandom_range(0, 40);
		endcase
	endfunction

	initial begin
		int r;
		bit [5:0] id;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_cmd(dtq_pkg::OP_PEEK, 0, 0);
		send_cmd(dtq_pkg::OP_TAKE, 63, 0);
		send_cmd(dtq_pkg::OP_REMOVE, 5, 0);
		send_cmd(dtq_pkg::OP_INSERT, 0, 32'hFFFF_FFFF);
		send_cmd(dtq_pkg::OP_INSERT, 63, 0);
		send_cmd(dtq_pkg::OP_INSERT, 10, 100);
		send_cmd(dtq_pkg::OP_INSERT, 11, 100);
		send_cmd(dtq_pkg::OP_INSERT, 12, 50);
		send_cmd(dtq_pkg::OP_INSERT, 10, 7);
		send_cmd(dtq_pkg::OP_PEEK, 0, 0);
		send_cmd(dtq_pkg::OP_REMOVE, 11, 0);
		send_cmd(dtq_pkg::OP_REMOVE, 11, 0);
		send_cmd(dtq_pkg::OP_TAKE, 0, 0);
		send_cmd(dtq_pkg::OP_REMOVE, 0, 0);
		send_cmd(dtq_pkg::OP_TAKE, 0, 0);
		send_cmd(dtq_pkg::OP_TAKE, 0, 0);
		send_cmd(dtq_pkg::OP_TAKE, 0, 0);
		send_cmd(dtq_pkg::OP_PEEK, 0, 0);
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 20; i++)
				send_cmd(dtq_pkg::OP_INSERT, $urandom_range(0, 63), rand_ticks());
		join
		for (int i = 0; i < 1250; i++) begin
			if (i > 1100) calm = 1;
			r = $urandom_range(0, 9);
			id = $urandom_range(0, 63);
			if (r < 5)
				send_cmd(dtq_pkg::OP_INSERT, id, rand_ticks());
			else if (r < 7)
				send_cmd(dtq_pkg::OP_REMOVE, id, 0);
			else if (r < 8)
				send_cmd(dtq_pkg::OP_PEEK, id, $urandom);
			else
				send_cmd(dtq_pkg::OP_TAKE, id, $urandom);
		end
		in_ch.valid <= 0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
